// ===== rtl/rpn_pkg.sv =====
// shared constants for the rpn stack calculator
package rpn_pkg;
   localparam int StackDepth = 64;
   localparam int AddrW = $clog2(StackDepth);
   localparam int CountW = $clog2(StackDepth + 1);

   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_ADD  = 3'd1;
   localparam logic [2:0] CMD_SUB  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_DIV  = 3'd4;
   localparam logic [2:0] CMD_MOD  = 3'd5;
   localparam logic [2:0] CMD_FACT = 3'd6;
   localparam logic [2:0] CMD_POW  = 3'd7;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_FEW      = 3'd2;
   localparam logic [2:0] ST_ZERO_DIV = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
endpackage

// ===== rtl/rpn_stack_calculator.sv =====
// rpn stack calculator top level: stack memory, sequencer and iterative arithmetic
//
// usage: one command per transfer on req_ (req_command, req_push_value); one result
// per command on rsp_ (rsp_status, rsp_top_value, rsp_depth). stall is driven by
// the receiver of each channel; a transfer happens when valid is high and stall low.
// the stack lives in a one-port synchronous memory with a registered read;
// the top of stack is also kept in a register, so only the second operand is read.
// states passed from the req_ transfer to rsp_valid, idle apart:
//   push, or an empty, short-stack or full error: done; zero division: read, done
//   factorial of x <= 1 or x >= 34: exec, done
//   power with a negative exponent: read, exec, done
//   add, sub, mul: read, iterate, exec, done
//   div, mod: read, iterate, one quotient bit per cycle over 32 steps, exec, done
//   factorial of x in 2..33: iterate, one multiply per factor, exec, done
//   power: read, per exponent bit a multiply if it is set, a square; exec, done
// one command is in flight at a time; the next is taken in the cycle after its result
// transfer, so a result waiting under rsp_stall holds the block and it stalls req_.
// reset clears the depth and the sequencer; stack contents are undefined until
// pushed, and only entries below the depth are ever read.
module rpn_stack_calculator
   import rpn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_top_value,
   output logic [6:0]         rsp_depth
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_ITER = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [31:0] mem [StackDepth];
   logic [31:0] rd_data_ff;

   logic [2:0]        state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [31:0]       top_ff, top_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [31:0]       a_ff, a_in, b_ff, b_in;
   logic [31:0]       acc_ff, acc_in;
   logic [31:0]       rem_ff, rem_in;
   logic [5:0]        step_ff, step_in;
   logic              phase_ff, phase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        status_ff, status_in;

   logic              mem_we;
   logic [AddrW-1:0]  mem_addr;
   logic [31:0]       mem_wdata;

   logic              take;
   logic [31:0]       abs_b, r_sh, sub_r;
   logic [32:0]       diff;
   logic [31:0]       div_res;
   logic [63:0]       prod;
   logic [31:0]       mul_x, mul_y;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign take = req_valid && !req_stall;

   assign abs_b = b_ff[31] ? (32'd0 - b_ff) : b_ff;
   // restoring divide step: acc holds the dividend shifting out, rem the remainder
   assign r_sh  = {rem_ff[30:0], acc_ff[31]};
   assign diff  = {1'b0, r_sh} - {1'b0, abs_b};
   assign sub_r = diff[31:0];
   assign prod  = mul_x * mul_y;

   // stack memory, one port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   // shared multiplier operand select
   always_comb begin
      mul_x = a_ff;
      mul_y = b_ff;
      case (cmd_ff)
         CMD_FACT: begin
            mul_x = acc_ff;
            mul_y = {26'd0, step_ff};
         end
         CMD_POW: begin
            if (phase_ff) begin
               mul_x = a_ff;
               mul_y = a_ff;
            end else begin
               mul_x = acc_ff;
               mul_y = a_ff;
            end
         end
         default: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
      endcase
   end

   always_comb begin
      div_res = (cmd_ff == CMD_DIV)
         ? (((a_ff[31] ^ b_ff[31])) ? (32'd0 - acc_ff) : acc_ff)
         : (a_ff[31] ? (32'd0 - rem_ff) : rem_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = top_ff;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd_in = req_command;
               status_in = ST_OK;
               if (req_command == CMD_PUSH) begin
                  if (count_ff >= CountW'(StackDepth)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_addr  = count_ff[AddrW-1:0];
                     mem_wdata = req_push_value;
                     top_in    = req_push_value;
                     count_in  = count_ff + CountW'(1);
                  end
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in = S_DONE;
               end else if (req_command == CMD_FACT) begin
                  acc_in  = 32'd1;
                  step_in = 6'd2;
                  if (top_ff[31] || top_ff <= 32'd1) begin
                     top_in   = 32'd1;
                     state_in = S_EXEC;
                  end else if (top_ff >= 32'd34) begin
                     top_in   = 32'd0;
                     state_in = S_EXEC;
                  end else begin
                     a_in     = top_ff;
                     state_in = S_ITER;
                  end
               end else if (count_ff < CountW'(2)) begin
                  status_in = ST_FEW;
                  state_in = S_DONE;
               end else begin
                  b_in     = top_ff;
                  mem_addr = AddrW'(count_ff - CountW'(2));
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            a_in     = rd_data_ff;
            acc_in   = 32'd1;
            rem_in   = '0;
            step_in  = '0;
            phase_in = 1'b0;
            state_in = S_ITER;
            if ((cmd_ff == CMD_DIV || cmd_ff == CMD_MOD) && b_ff == '0) begin
               status_in = ST_ZERO_DIV;
               state_in  = S_DONE;
            end else if (cmd_ff == CMD_DIV || cmd_ff == CMD_MOD) begin
               acc_in = rd_data_ff[31] ? (32'd0 - rd_data_ff) : rd_data_ff;
            end else if (cmd_ff == CMD_POW && b_ff[31]) begin
               if (rd_data_ff == 32'd1) top_in = 32'd1;
               else if (rd_data_ff == 32'hFFFF_FFFF)
                  top_in = b_ff[0] ? 32'hFFFF_FFFF : 32'd1;
               else top_in = 32'd0;
               count_in = count_ff - CountW'(1);
               state_in = S_EXEC;
            end
         end
         S_ITER: begin
            case (cmd_ff)
               CMD_ADD: begin
                  top_in = a_ff + b_ff;
                  count_in = count_ff - CountW'(1);
                  state_in = S_EXEC;
               end
               CMD_SUB: begin
                  top_in = a_ff - b_ff;
                  count_in = count_ff - CountW'(1);
                  state_in = S_EXEC;
               end
               CMD_MUL: begin
                  top_in = prod[31:0];
                  count_in = count_ff - CountW'(1);
                  state_in = S_EXEC;
               end
               CMD_DIV, CMD_MOD: begin
                  // one quotient bit per cycle, abs_b nonzero
                  if (!diff[32]) begin
                     rem_in = sub_r;
                     acc_in = {acc_ff[30:0], 1'b1};
                  end else begin
                     rem_in = r_sh;
                     acc_in = {acc_ff[30:0], 1'b0};
                  end
                  step_in = step_ff + 6'd1;
                  if (step_ff == 6'd31) begin
                     phase_in = 1'b1;
                     state_in = S_ITER;
                  end
                  if (phase_ff) begin
                     acc_in   = acc_ff;
                     rem_in   = rem_ff;
                     top_in   = div_res;
                     count_in = count_ff - CountW'(1);
                     state_in = S_EXEC;
                  end
               end
               CMD_FACT: begin
                  acc_in  = prod[31:0];
                  step_in = step_ff + 6'd1;
                  if ({26'd0, step_ff} == a_ff) begin
                     top_in   = prod[31:0];
                     state_in = S_EXEC;
                  end
               end
               default: begin
                  // power: multiply when low exponent bit set, then square
                  if (b_ff == '0) begin
                     top_in   = acc_ff;
                     count_in = count_ff - CountW'(1);
                     state_in = S_EXEC;
                  end else if (!phase_ff) begin
                     if (b_ff[0]) acc_in = prod[31:0];
                     phase_in = 1'b1;
                  end else begin
                     a_in     = prod[31:0];
                     b_in     = {1'b0, b_ff[31:1]};
                     phase_in = 1'b0;
                  end
               end
            endcase
         end
         S_EXEC: begin
            // write result back at the new top
            mem_we    = 1'b1;
            mem_addr  = AddrW'(count_ff - CountW'(1));
            mem_wdata = top_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
      top_ff    <= top_in;
      cmd_ff    <= cmd_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      status_ff <= status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_top_value = (count_ff == '0) ? 32'sd0 : top_ff;
   assign rsp_depth     = 7'(count_ff);
endmodule
